// ===== rtl/core/svda_pkg.sv =====
// Package: types, constants and sizes shared by the species-keyed voxel dose accumulator.
package svda_pkg;

  localparam int VOXELS_X    = 16;
  localparam int VOXELS_Y    = 16;
  localparam int VOXELS_Z    = 64;
  localparam int MAX_SPECIES = 8;

  localparam int NVOX      = VOXELS_X * VOXELS_Y * VOXELS_Z;
  localparam int VOX_W     = (NVOX > 1) ? $clog2(NVOX) : 1;
  localparam int SPC_DEPTH = MAX_SPECIES * NVOX;
  localparam int SPC_AW    = (SPC_DEPTH > 1) ? $clog2(SPC_DEPTH) : 1;
  localparam int SLOT_W    = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
  localparam int CNT_W     = $clog2(MAX_SPECIES + 1);

  localparam int DOSE_W = 48;
  localparam int FLU_W  = 32;
  localparam int CODE_W = 32;

  // floor(v / 10) = (v * RECIP10) >> RECIP10_SHIFT, exact for 32-bit unsigned v
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [SPC_AW-1:0] CLR_LAST = SPC_AW'(SPC_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_TOTAL   = 2'd1,
    OP_SPECIES = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_KEY,
    S_NEG,
    S_MATCH,
    S_READ,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic               is_primary;
    logic signed [31:0] particle_code;
    logic [3:0]         voxel_x;
    logic [3:0]         voxel_y;
    logic [5:0]         voxel_z;
    logic [31:0]        energy;
    logic               count_fluence;
    logic [3:0]         read_slot;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         slot_used;
    logic [47:0]        dose_value;
    logic [31:0]        fluence_value;
    logic signed [31:0] slot_code;
    logic               slot_primary;
    logic [3:0]         species_in_use;
  } out_item_t;

  typedef struct packed {
    logic              tot_we;
    logic [VOX_W-1:0]  tot_addr;
    logic [DOSE_W-1:0] tot_wdata;
    logic              spc_we;
    logic [SPC_AW-1:0] spc_addr;
    logic [DOSE_W-1:0] spc_dose_wdata;
    logic [FLU_W-1:0]  spc_flu_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DOSE_W-1:0] tot_dose;
    logic [DOSE_W-1:0] spc_dose;
    logic [FLU_W-1:0]  spc_flu;
  } mem_rsp_t;

  function automatic logic voxel_in_range(logic [3:0] x, logic [3:0] y, logic [5:0] z);
    return (32'(x) < VOXELS_X) && (32'(y) < VOXELS_Y) && (32'(z) < VOXELS_Z);
  endfunction

  function automatic logic [VOX_W-1:0] voxel_index(logic [3:0] x, logic [3:0] y,
                                                   logic [5:0] z);
    return VOX_W'((32'(x) * VOXELS_Y + 32'(y)) * VOXELS_Z + 32'(z));
  endfunction

endpackage

// ===== rtl/core/species_keyed_voxel_dose_accumulator.sv =====
// Top level: species-keyed voxel dose accumulator with its command sequencer.
//
// Commands are taken when start is high and busy is low; each one gives exactly one
// result, shown for a single cycle with out_strobe, and the receiver cannot stall it.
// After reset the block sweeps all MAX_SPECIES*NVOX store words to zero with busy high; a
// clear command runs the same sweep and then gives its result. A total deposit does one
// read-modify-write of the dose memory and a read does one memory read. A species deposit
// forms its code, rounded toward zero to a multiple of ten, with a reciprocal multiply, a
// shift-and-add step and a sign step, then compares the slot table one entry a cycle (up to
// MAX_SPECIES + 1 steps) before the memory read-modify-write. busy drops the cycle after the
// strobe; commands rejected on arrival give their result the cycle after acceptance.
module species_keyed_voxel_dose_accumulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  svda_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_strobe,
  output svda_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import svda_pkg::*;

  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic [VOX_W-1:0]    vox_r;
  logic [31:0]         abs_r;
  logic                neg_r;
  logic [63:0]         prod_r;
  logic [31:0]         m10_r;
  logic [CODE_W-1:0]   key_r;
  logic [CNT_W-1:0]    idx_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    slots_r;
  logic                acc_r;
  logic                clr_resp_r;
  logic [SPC_AW-1:0]   cnt_r;
  logic                en_r;
  logic [CODE_W-1:0]   code_tab_r [MAX_SPECIES];
  logic                prim_tab_r [MAX_SPECIES];

  logic                in_range_w;
  logic [VOX_W-1:0]    vox_w;
  logic                spc_ok_w;
  logic                rd_ok_w;
  logic [SLOT_W-1:0]   tab_idx;
  logic [CODE_W-1:0]   tab_code;
  logic                tab_prim;
  logic                hit_w;
  logic                table_full_w;
  logic [28:0]         quot_w;
  logic [DOSE_W-1:0]   add_a;
  logic [DOSE_W:0]     add_sum;
  logic [DOSE_W-1:0]   dose_sat;
  logic [FLU_W-1:0]    flu_next;
  logic [SPC_AW-1:0]   spc_addr_w;
  mem_req_t            mem_req;
  mem_rsp_t            mem_rsp;

  assign in_range_w = voxel_in_range(in_item.voxel_x, in_item.voxel_y, in_item.voxel_z);
  assign vox_w      = voxel_index(in_item.voxel_x, in_item.voxel_y, in_item.voxel_z);
  assign spc_ok_w   = in_range_w && en_r && (in_item.energy != '0 || in_item.count_fluence);
  assign rd_ok_w    = in_range_w && ((32'(in_item.read_slot) == MAX_SPECIES) ||
                                     (32'(in_item.read_slot) < 32'(slots_r)));

  assign tab_idx      = (state_r == S_MATCH) ? idx_r[SLOT_W-1:0] : slot_r;
  assign tab_code     = code_tab_r[tab_idx];
  assign tab_prim     = prim_tab_r[tab_idx];
  assign hit_w        = (idx_r < slots_r) && (tab_code == key_r) &&
                        (tab_prim == item_r.is_primary);
  assign table_full_w = (32'(slots_r) >= MAX_SPECIES);
  assign quot_w       = prod_r[63:RECIP10_SHIFT];

  // shared saturating dose adder
  assign add_a    = (item_r.opcode == OP_TOTAL) ? mem_rsp.tot_dose : mem_rsp.spc_dose;
  assign add_sum  = {1'b0, add_a} + (DOSE_W + 1)'(item_r.energy);
  assign dose_sat = add_sum[DOSE_W] ? '1 : add_sum[DOSE_W-1:0];
  assign flu_next = (item_r.count_fluence && mem_rsp.spc_flu != '1) ?
                    mem_rsp.spc_flu + FLU_W'(1) : mem_rsp.spc_flu;

  assign spc_addr_w = SPC_AW'(32'(slot_r) * NVOX + 32'(vox_r));

  always_comb begin
    mem_req = '0;
    if (state_r == S_CLEAR) begin
      mem_req.tot_we   = (32'(cnt_r) < NVOX);
      mem_req.tot_addr = cnt_r[VOX_W-1:0];
      mem_req.spc_we   = 1'b1;
      mem_req.spc_addr = cnt_r;
    end else begin
      mem_req.tot_we         = (state_r == S_WRITE) && (item_r.opcode == OP_TOTAL);
      mem_req.tot_addr       = vox_r;
      mem_req.tot_wdata      = dose_sat;
      mem_req.spc_we         = (state_r == S_WRITE) && (item_r.opcode == OP_SPECIES);
      mem_req.spc_addr       = spc_addr_w;
      mem_req.spc_dose_wdata = dose_sat;
      mem_req.spc_flu_wdata  = flu_next;
    end
  end

  svda_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == CLR_LAST) state_nxt = clr_resp_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (in_item.opcode)
            OP_CLEAR:   state_nxt = S_CLEAR;
            OP_TOTAL:   state_nxt = in_range_w ? S_READ : S_DONE;
            OP_SPECIES: state_nxt = spc_ok_w ? S_MUL : S_DONE;
            OP_READ:    state_nxt = rd_ok_w ? S_READ : S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL: state_nxt = S_KEY;
      S_KEY: state_nxt = S_NEG;
      S_NEG: state_nxt = S_MATCH;
      S_MATCH: begin
        if (hit_w) begin
          state_nxt = S_READ;
        end else if (idx_r == slots_r) begin
          state_nxt = table_full_w ? S_DONE : S_READ;
        end
      end
      S_READ:  state_nxt = (item_r.opcode == OP_READ) ? S_DONE : S_WRITE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r    <= '0;
      en_r       <= 1'b0;
      acc_r      <= 1'b0;
      clr_resp_r <= 1'b0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else begin
      if (cfg_we) en_r <= cfg_wdata;
      case (state_r)
        S_CLEAR: cnt_r <= cnt_r + SPC_AW'(1);
        S_IDLE: begin
          if (start) begin
            clr_resp_r <= 1'b1;
            cnt_r      <= '0;
            idx_r      <= '0;
            case (in_item.opcode)
              OP_CLEAR: begin
                slots_r <= '0;
                acc_r   <= 1'b1;
              end
              OP_TOTAL: acc_r <= in_range_w;
              OP_READ:  acc_r <= rd_ok_w;
              default:  acc_r <= 1'b0;
            endcase
          end
        end
        S_MATCH: begin
          if (hit_w) begin
            acc_r <= 1'b1;
          end else if (idx_r == slots_r) begin
            if (!table_full_w) begin
              acc_r   <= 1'b1;
              slots_r <= slots_r + CNT_W'(1);
            end
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_r <= in_item;
          vox_r  <= vox_w;
          slot_r <= in_item.read_slot[SLOT_W-1:0];
          neg_r  <= in_item.particle_code[31];
          abs_r  <= in_item.particle_code[31] ? 32'(-in_item.particle_code)
                                              : 32'(in_item.particle_code);
        end
      end
      S_MUL: prod_r <= abs_r * RECIP10;
      S_KEY: m10_r  <= {quot_w[28:0], 3'b000} + {2'b00, quot_w[28:0], 1'b0};
      S_NEG: key_r  <= neg_r ? 32'(-m10_r) : m10_r;
      S_MATCH: begin
        if (hit_w) begin
          slot_r <= idx_r[SLOT_W-1:0];
        end else if (idx_r == slots_r && !table_full_w) begin
          slot_r                                <= slots_r[SLOT_W-1:0];
          code_tab_r[slots_r[SLOT_W-1:0]] <= key_r;
          prim_tab_r[slots_r[SLOT_W-1:0]] <= item_r.is_primary;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    busy       = (state_r != S_IDLE);
    out_strobe = (state_r == S_DONE);
    out_item   = '0;
    out_item.accepted       = acc_r;
    out_item.species_in_use = 4'(slots_r);
    if (acc_r) begin
      case (item_r.opcode)
        OP_SPECIES: out_item.slot_used = 3'(slot_r);
        OP_READ: begin
          if (32'(item_r.read_slot) == MAX_SPECIES) begin
            out_item.dose_value = mem_rsp.tot_dose;
          end else begin
            out_item.dose_value    = mem_rsp.spc_dose;
            out_item.fluence_value = mem_rsp.spc_flu;
            out_item.slot_code     = tab_code;
            out_item.slot_primary  = tab_prim;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/svda_mem.sv =====
// Voxel dose stores: total dose, per-species dose and per-species fluence, registered reads.
module svda_mem (
  input  logic               clk,
  input  svda_pkg::mem_req_t mem_req,
  output svda_pkg::mem_rsp_t mem_rsp
);
  import svda_pkg::*;

  logic [DOSE_W-1:0] tot_mem      [NVOX];
  logic [DOSE_W-1:0] spc_dose_mem [SPC_DEPTH];
  logic [FLU_W-1:0]  spc_flu_mem  [SPC_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.tot_we) begin
      tot_mem[mem_req.tot_addr] <= mem_req.tot_wdata;
    end
    if (mem_req.spc_we) begin
      spc_dose_mem[mem_req.spc_addr] <= mem_req.spc_dose_wdata;
      spc_flu_mem[mem_req.spc_addr]  <= mem_req.spc_flu_wdata;
    end
    mem_rsp.tot_dose <= tot_mem[mem_req.tot_addr];
    mem_rsp.spc_dose <= spc_dose_mem[mem_req.spc_addr];
    mem_rsp.spc_flu  <= spc_flu_mem[mem_req.spc_addr];
  end

endmodule

// ===== rtl/core/svda_checker.sv =====
// Port-level checker for the species-keyed voxel dose accumulator, with its bind.
module svda_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input svda_pkg::out_item_t out_item
);
  import svda_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe not followed by ready");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result shown while ready for a new transaction");

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> 32'(out_item.species_in_use) <= MAX_SPECIES)
    else $error("species count beyond table size");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.accepted |->
      out_item.dose_value == '0 && out_item.fluence_value == '0 &&
      out_item.slot_used == '0)
    else $error("rejected transaction carries data");

endmodule

bind species_keyed_voxel_dose_accumulator svda_checker u_svda_checker (.*);
